// ----- rtl/core/selr_pkg.sv -----
// Package for the sequenced event log ring: command and result types,
// mode and kind codes, default sizes. No dependencies.
package selr_pkg;

    localparam int CAPACITY_DEF     = 32;
    localparam int MAX_HOPS_DEF     = 8;
    localparam int DEDUPE_DEPTH_DEF = 64;
    localparam int OUT_LIMIT        = 32;

    typedef enum logic [1:0] {
        MODE_APPEND   = 2'd0,
        MODE_LATEST   = 2'd1,
        MODE_LIST     = 2'd2,
        MODE_RECEIPTS = 2'd3
    } mode_t;

    localparam logic [2:0] KIND_ACK    = 3'd0;
    localparam logic [2:0] KIND_LATEST = 3'd1;
    localparam logic [2:0] KIND_RECORD = 3'd2;
    localparam logic [2:0] KIND_RCPT   = 3'd3;
    localparam logic [2:0] KIND_DONE   = 3'd4;

    // classified request as queued between front and back
    typedef struct packed {
        mode_t       mode;
        logic [31:0] msg;
        logic [31:0] rcpt;
        logic [3:0]  hops;     // already clamped
        logic [31:0] payload;
        logic [31:0] since;
        logic [5:0]  limit;    // already clamped to OUT_LIMIT
    } cmd_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] seq_num;
        logic [31:0] msg;
        logic [31:0] rcpt;
        logic [3:0]  hops;
        logic [31:0] payload;
        logic [5:0]  written;
        logic [6:0]  unique_total;
        logic        last;
    } res_t;

endpackage

// ----- rtl/core/selr_front.sv -----
// Front end: takes input requests, clamps hops and max count, and queues
// them in a two-entry buffer for the back end. Uses selr_pkg.
module selr_front
    import selr_pkg::*;
#(
    parameter int MAX_HOPS = MAX_HOPS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    output logic         cmd_valid,
    input  logic         cmd_ready,
    output cmd_t         cmd
);

    cmd_t       q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       head_reg, head_next;
    logic       push, pop;
    cmd_t       in_cmd;
    logic [7:0] hop_in;
    logic [5:0] lim_in;

    always_comb
    begin
        hop_in          = s_axis_tdata[71:64];
        lim_in          = s_axis_tdata[141:136];
        in_cmd.mode     = mode_t'(s_axis_tuser);
        in_cmd.msg      = s_axis_tdata[31:0];
        in_cmd.rcpt     = s_axis_tdata[63:32];
        in_cmd.hops     = (hop_in > 8'(MAX_HOPS)) ? 4'(MAX_HOPS) : hop_in[3:0];
        in_cmd.payload  = s_axis_tdata[103:72];
        in_cmd.since    = s_axis_tdata[135:104];
        in_cmd.limit    = (lim_in > 6'(OUT_LIMIT)) ? 6'(OUT_LIMIT) : lim_in;
    end

    assign s_axis_tready = (cnt_reg != 2'd2);
    assign cmd_valid     = (cnt_reg != 2'd0);
    assign cmd           = q_reg[head_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = cmd_valid && cmd_ready;

    always_comb
    begin
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
        head_next = pop ? ~head_reg : head_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            head_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[head_reg ^ cnt_reg[0]] <= in_cmd;
        end
    end

endmodule

// ----- rtl/core/selr_back.sv -----
// Back end: runs appends and query scans over the record memory and the
// dedupe memory, and holds the output register. Uses selr_pkg.
module selr_back
    import selr_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int DEDUPE_DEPTH = DEDUPE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IW  = $clog2(CAPACITY + 1);
    localparam int SW  = (DEDUPE_DEPTH > 1) ? $clog2(DEDUPE_DEPTH) : 1;
    localparam int SCW = $clog2(DEDUPE_DEPTH + 1);

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] msg;
        logic [31:0] rcpt;
        logic [3:0]  hops;
        logic [31:0] payload;
    } rec_t;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DISP = 8'b0000_0010,
        ST_RD   = 8'b0000_0100,
        ST_EV   = 8'b0000_1000,
        ST_DRD  = 8'b0001_0000,
        ST_DEV  = 8'b0010_0000,
        ST_NEW  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    rec_t        rec_mem [CAPACITY];
    logic [31:0] seen_mem [DEDUPE_DEPTH];

    state_t      state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [IW-1:0]  i_reg, i_next;
    logic [5:0]     wr_reg, wr_next;
    logic [SCW-1:0] j_reg, j_next;
    logic [SCW-1:0] seen_cnt_reg, seen_cnt_next;
    logic [AW-1:0]  wptr_reg, wptr_next;
    logic [IW-1:0]  fill_reg, fill_next;
    logic [31:0]    nseq_reg, nseq_next;
    logic           ov_reg, ov_next;
    res_t           res_reg, res_next;
    rec_t           rec_rd_reg;
    logic [31:0]    seen_rd_reg;

    logic           out_free, emit, rec_we, rd_en, seen_we, seen_rd_en;
    res_t           emit_res;
    rec_t           wr_rec;
    logic [AW-1:0]  start, slot;
    logic [AW:0]    slot_sum;
    logic [8:0]     cnt_ext;
    logic [6:0]     uniq_sat;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = ov_reg;
    assign res       = res_reg;
    assign out_free  = !ov_reg || res_ready;

    always_comb
    begin
        start    = (fill_reg == IW'(CAPACITY)) ? wptr_reg : '0;
        slot_sum = (AW + 1)'(start) + (AW + 1)'(i_reg);
        if (slot_sum >= (AW + 1)'(CAPACITY))
        begin
            slot_sum = slot_sum - (AW + 1)'(CAPACITY);
        end
        slot     = slot_sum[AW-1:0];
        cnt_ext  = 9'(seen_cnt_reg);
        uniq_sat = (cnt_ext > 9'd127) ? 7'd127 : cnt_ext[6:0];
        wr_rec.seq     = nseq_reg;
        wr_rec.msg     = cmd_reg.msg;
        wr_rec.rcpt    = cmd_reg.rcpt;
        wr_rec.hops    = cmd_reg.hops;
        wr_rec.payload = cmd_reg.payload;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        i_next        = i_reg;
        wr_next       = wr_reg;
        j_next        = j_reg;
        seen_cnt_next = seen_cnt_reg;
        wptr_next     = wptr_reg;
        fill_next     = fill_reg;
        nseq_next     = nseq_reg;
        emit          = 1'b0;
        emit_res      = '0;
        rec_we        = 1'b0;
        rd_en         = 1'b0;
        seen_we       = 1'b0;
        seen_rd_en    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                i_next  = '0;
                wr_next = '0;
                case (cmd_reg.mode)
                    MODE_APPEND:
                    begin
                        if (out_free)
                        begin
                            rec_we           = 1'b1;
                            emit             = 1'b1;
                            emit_res.kind    = KIND_ACK;
                            emit_res.seq_num = nseq_reg;
                            emit_res.last    = 1'b1;
                            wptr_next  = (wptr_reg == AW'(CAPACITY - 1)) ? '0
                                                                         : wptr_reg + 1'b1;
                            if (fill_reg != IW'(CAPACITY))
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                            nseq_next  = nseq_reg + 32'd1;
                            state_next = ST_IDLE;
                        end
                    end
                    MODE_LATEST:
                    begin
                        if (out_free)
                        begin
                            emit             = 1'b1;
                            emit_res.kind    = KIND_LATEST;
                            emit_res.seq_num = (fill_reg != '0 && nseq_reg != 32'd0)
                                               ? nseq_reg - 32'd1 : 32'd0;
                            emit_res.last    = 1'b1;
                            state_next       = ST_IDLE;
                        end
                    end
                    MODE_LIST:
                    begin
                        state_next = ST_RD;
                    end
                    default:
                    begin
                        seen_cnt_next = '0;
                        state_next    = (cmd_reg.msg == 32'd0) ? ST_DONE : ST_RD;
                    end
                endcase
            end
            ST_RD:
            begin
                if (i_reg == fill_reg ||
                    (cmd_reg.mode == MODE_LIST && wr_reg == cmd_reg.limit))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_EV;
                end
            end
            ST_EV:
            begin
                if (cmd_reg.mode == MODE_LIST)
                begin
                    if (rec_rd_reg.seq > cmd_reg.since)
                    begin
                        if (out_free)
                        begin
                            emit                 = 1'b1;
                            emit_res.kind        = KIND_RECORD;
                            emit_res.seq_num     = rec_rd_reg.seq;
                            emit_res.msg         = rec_rd_reg.msg;
                            emit_res.rcpt        = rec_rd_reg.rcpt;
                            emit_res.hops        = rec_rd_reg.hops;
                            emit_res.payload     = rec_rd_reg.payload;
                            wr_next    = wr_reg + 6'd1;
                            i_next     = i_reg + 1'b1;
                            state_next = ST_RD;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
                else if (rec_rd_reg.msg != cmd_reg.msg || rec_rd_reg.rcpt == 32'd0)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_RD;
                end
                else
                begin
                    j_next     = '0;
                    state_next = (seen_cnt_reg == '0) ? ST_NEW : ST_DRD;
                end
            end
            ST_DRD:
            begin
                seen_rd_en = 1'b1;
                state_next = ST_DEV;
            end
            ST_DEV:
            begin
                if (seen_rd_reg == rec_rd_reg.rcpt)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_RD;
                end
                else if ((j_reg + SCW'(1)) == seen_cnt_reg)
                begin
                    state_next = ST_NEW;
                end
                else
                begin
                    j_next     = j_reg + SCW'(1);
                    state_next = ST_DRD;
                end
            end
            ST_NEW:
            begin
                // track and return together, so a stall never tracks twice
                if (wr_reg >= cmd_reg.limit || out_free)
                begin
                    if (wr_reg < cmd_reg.limit)
                    begin
                        emit          = 1'b1;
                        emit_res.kind = KIND_RCPT;
                        emit_res.rcpt = rec_rd_reg.rcpt;
                        wr_next       = wr_reg + 6'd1;
                    end
                    if (seen_cnt_reg < SCW'(DEDUPE_DEPTH))
                    begin
                        seen_we       = 1'b1;
                        seen_cnt_next = seen_cnt_reg + SCW'(1);
                    end
                    i_next     = i_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    emit             = 1'b1;
                    emit_res.kind    = KIND_DONE;
                    emit_res.written = wr_reg;
                    emit_res.unique_total = (cmd_reg.mode == MODE_RECEIPTS) ? uniq_sat
                                                                            : 7'd0;
                    emit_res.last    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        ov_next  = ov_reg && !res_ready;
        res_next = res_reg;
        if (emit)
        begin
            ov_next  = 1'b1;
            res_next = emit_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            i_reg        <= '0;
            wr_reg       <= '0;
            j_reg        <= '0;
            seen_cnt_reg <= '0;
            wptr_reg     <= '0;
            fill_reg     <= '0;
            nseq_reg     <= 32'd1;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            wr_reg       <= wr_next;
            j_reg        <= j_next;
            seen_cnt_reg <= seen_cnt_next;
            wptr_reg     <= wptr_next;
            fill_reg     <= fill_next;
            nseq_reg     <= nseq_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[wptr_reg] <= wr_rec;
        end
        if (rd_en)
        begin
            rec_rd_reg <= rec_mem[slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[seen_cnt_reg[SW-1:0]] <= rec_rd_reg.rcpt;
        end
        if (seen_rd_en)
        begin
            seen_rd_reg <= seen_mem[j_reg[SW-1:0]];
        end
    end

endmodule

// ----- rtl/core/sequenced_event_log_ring.sv -----
// Sequenced event log ring, top level. Append stores the record and acks; latest
// returns the newest sequence number. List since scans the stored records and returns
// each newer one up to the limit, then done. Receipts scans for the message, compares
// each recipient with the seen set and returns new ones (message 0 goes straight to
// done); each memory has a single read port. One request runs at a time; front queue
// holds two requests. rst_n is async, active low; memories are not cleared.
module sequenced_event_log_ring
    import selr_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,     // stored records
    parameter int MAX_HOPS     = MAX_HOPS_DEF,     // hop clamp
    parameter int DEDUPE_DEPTH = DEDUPE_DEPTH_DEF  // seen-set entries
)
(
    input  logic         clk,
    input  logic         rst_n,
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // msg_ident[31:0], recipient[63:32], hop_count[71:64], payload[103:72],
    // since_seq[135:104], max_out[141:136], zero fill
    input  logic [143:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,   // mode
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // seq_num[31:0], out_msg[63:32], out_recipient[95:64], out_hops[99:96],
    // out_payload[131:100], written[137:132], unique_total[144:138], zero fill
    output logic [151:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,   // kind
    output logic         m_axis_tlast
);

    logic cmd_valid, cmd_ready;
    cmd_t cmd;
    res_t res;

    // front: accept and classify requests into a short queue
    selr_front #(
        .MAX_HOPS (MAX_HOPS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    // back: log storage, scans, dedupe and the output register
    selr_back #(
        .CAPACITY     (CAPACITY),
        .DEDUPE_DEPTH (DEDUPE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;
    assign m_axis_tdata = {7'd0, res.unique_total, res.written, res.payload,
                           res.hops, res.rcpt, res.msg, res.seq_num};

endmodule

// ----- tb/sv/sequenced_event_log_ring_test.sv -----
// Testbench for the sequenced event log ring: directed and random requests with
// a self-checking scoreboard. Depends on selr_pkg and sequenced_event_log_ring.
`timescale 1ns / 1ps

module sequenced_event_log_ring_test;
    import selr_pkg::*;

    localparam int RING_DEPTH = 32;
    localparam int HOP_CLAMP  = 8;
    localparam int SEEN_DEPTH = 64;
    localparam int STALL_LIMIT = 40000;

    // Scoreboard: mirrors the log, predicts results per request, checks them in order.
    class event_log_scoreboard;
        logic [31:0] seq_mem [RING_DEPTH];
        logic [31:0] msg_mem [RING_DEPTH];
        logic [31:0] rcpt_mem [RING_DEPTH];
        logic [3:0]  hops_mem [RING_DEPTH];
        logic [31:0] pay_mem [RING_DEPTH];
        int unsigned wr_slot;
        int unsigned fill;
        logic [31:0] seq_ctr;
        res_t        pending[$];
        int          errors;
        int          checked;

        function new();
            wr_slot  = 0;
            fill     = 0;
            seq_ctr  = 32'd1;
            errors   = 0;
            checked  = 0;
        endfunction

        function void push(logic [2:0] kind, logic [31:0] seq, logic [31:0] msg,
                           logic [31:0] rcpt, logic [3:0] hops, logic [31:0] pay,
                           logic [5:0] wr, logic [6:0] uniq, logic lst);
            res_t r;
            r.kind = kind; r.seq_num = seq; r.msg = msg; r.rcpt = rcpt; r.hops = hops;
            r.payload = pay; r.written = wr; r.unique_total = uniq; r.last = lst;
            pending.push_back(r);
        endfunction

        // Accepted request: update the mirror and queue what it should produce.
        function void note_request(mode_t mode, logic [31:0] msg, logic [31:0] rcpt,
                                   logic [7:0] hop_in, logic [31:0] pay,
                                   logic [31:0] since, logic [5:0] max_in);
            int unsigned lim, start, s, wr, nseen;
            logic [31:0] seen [SEEN_DEPTH];
            logic [31:0] r;
            logic [31:0] latest;
            bit dup;
            lim = (max_in > 6'd32) ? 32 : max_in;
            start = (fill < RING_DEPTH) ? 0 : wr_slot;
            wr = 0;
            case (mode)
                MODE_APPEND:
                begin
                    seq_mem[wr_slot]  = seq_ctr;
                    msg_mem[wr_slot]  = msg;
                    rcpt_mem[wr_slot] = rcpt;
                    hops_mem[wr_slot] = (hop_in > HOP_CLAMP) ? 4'(HOP_CLAMP) : hop_in[3:0];
                    pay_mem[wr_slot]  = pay;
                    wr_slot = (wr_slot + 1) % RING_DEPTH;
                    if (fill < RING_DEPTH)
                        fill++;
                    push(KIND_ACK, seq_ctr, 0, 0, 0, 0, 0, 0, 1'b1);
                    seq_ctr = seq_ctr + 32'd1;
                end
                MODE_LATEST:
                begin
                    latest = (fill != 0 && seq_ctr != 0) ? seq_ctr - 32'd1 : 32'd0;
                    push(KIND_LATEST, latest, 0, 0, 0, 0, 0, 0, 1'b1);
                end
                MODE_LIST:
                begin
                    for (int i = 0; i < fill && wr < lim; i++)
                    begin
                        s = (start + i) % RING_DEPTH;
                        if (seq_mem[s] > since)
                        begin
                            push(KIND_RECORD, seq_mem[s], msg_mem[s], rcpt_mem[s],
                                 hops_mem[s], pay_mem[s], 0, 0, 1'b0);
                            wr++;
                        end
                    end
                    push(KIND_DONE, 0, 0, 0, 0, 0, 6'(wr), 0, 1'b1);
                end
                default:
                begin
                    nseen = 0;
                    if (msg != 0)
                    begin
                        for (int i = 0; i < fill; i++)
                        begin
                            s = (start + i) % RING_DEPTH;
                            r = rcpt_mem[s];
                            if (msg_mem[s] != msg || r == 0)
                                continue;
                            dup = 1'b0;
                            for (int j = 0; j < nseen; j++)
                                if (seen[j] == r)
                                    dup = 1'b1;
                            if (dup)
                                continue;
                            if (nseen < SEEN_DEPTH)
                            begin
                                seen[nseen] = r;
                                nseen++;
                            end
                            if (wr < lim)
                            begin
                                push(KIND_RCPT, 0, 0, r, 0, 0, 0, 0, 1'b0);
                                wr++;
                            end
                        end
                    end
                    push(KIND_DONE, 0, 0, 0, 0, 0, 6'(wr),
                         (nseen > 127) ? 7'd127 : 7'(nseen), 1'b1);
                end
            endcase
        endfunction

        function void check_result(res_t got);
            res_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected result kind=%0d", got.kind);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (got.kind != exp_r.kind)
            begin
                $error("kind exp %0d got %0d", exp_r.kind, got.kind); errors++;
            end
            if (got.seq_num != exp_r.seq_num)
            begin
                $error("seq_num exp %0h got %0h", exp_r.seq_num, got.seq_num); errors++;
            end
            if (got.msg != exp_r.msg)
            begin
                $error("out_msg exp %0h got %0h", exp_r.msg, got.msg); errors++;
            end
            if (got.rcpt != exp_r.rcpt)
            begin
                $error("out_recipient exp %0h got %0h", exp_r.rcpt, got.rcpt); errors++;
            end
            if (got.hops != exp_r.hops)
            begin
                $error("out_hops exp %0d got %0d", exp_r.hops, got.hops); errors++;
            end
            if (got.payload != exp_r.payload)
            begin
                $error("out_payload exp %0h got %0h", exp_r.payload, got.payload); errors++;
            end
            if (got.written != exp_r.written)
            begin
                $error("written exp %0d got %0d", exp_r.written, got.written); errors++;
            end
            if (got.unique_total != exp_r.unique_total)
            begin
                $error("unique_total exp %0d got %0d", exp_r.unique_total,
                       got.unique_total); errors++;
            end
            if (got.last != exp_r.last)
            begin
                $error("last exp %0d got %0d", exp_r.last, got.last); errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // msg_ident, recipient, hop_count, payload, since_seq, max_out, zero fill
    logic [143:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;   // mode
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // seq_num, out_msg, out_recipient, out_hops, out_payload, written, unique_total
    logic [151:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;   // kind
    logic         m_axis_tlast;

    event_log_scoreboard sb;
    int idle_pct;      // sender gap chance per cycle
    int stall_pct;     // receiver stall chance per cycle
    int quiet_cycles;
    int n_append, n_latest, n_list, n_rcpt;

    sequenced_event_log_ring u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    // Result side: check every accepted result, then pick the next ready level.
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind         = m_axis_tuser;
            got.seq_num      = m_axis_tdata[31:0];
            got.msg          = m_axis_tdata[63:32];
            got.rcpt         = m_axis_tdata[95:64];
            got.hops         = m_axis_tdata[99:96];
            got.payload      = m_axis_tdata[131:100];
            got.written      = m_axis_tdata[137:132];
            got.unique_total = m_axis_tdata[144:138];
            got.last         = m_axis_tlast;
            sb.check_result(got);
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // One request: optional gap, then hold valid until the block takes it.
    task automatic send_request(mode_t mode, logic [31:0] msg, logic [31:0] rcpt,
                                logic [7:0] hops, logic [31:0] pay,
                                logic [31:0] since, logic [5:0] max_out);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {2'b0, max_out, since, pay, hops, rcpt, msg};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(mode, msg, rcpt, hops, pay, since, max_out);
        case (mode)
            MODE_APPEND: n_append++;
            MODE_LATEST: n_latest++;
            MODE_LIST:   n_list++;
            default:     n_rcpt++;
        endcase
    endtask

    task automatic send_random();
        int pick;
        int rsel;
        logic [31:0] msg, rcpt, since;
        pick = $urandom_range(99);
        rsel = $urandom_range(99);
        msg  = ($urandom_range(4) == 0) ? $urandom : 32'($urandom_range(1, 4));
        if (rsel < 10)
            rcpt = 0;
        else if (rsel < 80)
            rcpt = 32'($urandom_range(1, 6));
        else
            rcpt = $urandom;
        if (pick < 45)
            send_request(MODE_APPEND, msg, rcpt,
                         ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(10)),
                         $urandom, $urandom, 6'($urandom));
        else if (pick < 55)
            send_request(MODE_LATEST, $urandom, $urandom, 8'($urandom), $urandom,
                         $urandom, 6'($urandom));
        else if (pick < 75)
        begin
            since = ($urandom_range(5) == 0) ? $urandom
                                             : sb.seq_ctr - 32'($urandom_range(40));
            send_request(MODE_LIST, $urandom, $urandom, 8'($urandom), $urandom,
                         since, 6'($urandom));
        end
        else
            send_request(MODE_RECEIPTS, ($urandom_range(9) == 0) ? 32'd0 : msg,
                         $urandom, 8'($urandom), $urandom, $urandom, 6'($urandom));
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_APPEND;
        m_axis_tready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        n_append = 0; n_latest = 0; n_list = 0; n_rcpt = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty log: latest gives 0, list and receipts queries give done only.
        send_request(MODE_LATEST, 0, 0, 0, 0, 0, 0);
        send_request(MODE_LIST, 0, 0, 0, 0, 0, 6'd32);
        send_request(MODE_RECEIPTS, 32'd5, 0, 0, 0, 0, 6'd63);
        // Field extremes and hop clamp edges.
        send_request(MODE_APPEND, 0, 0, 0, 0, 0, 0);
        send_request(MODE_APPEND, '1, '1, 8'hff, '1, '1, 6'h3f);
        send_request(MODE_APPEND, 32'd5, 32'd7, 8'd8, 32'h1234, 0, 0);
        send_request(MODE_APPEND, 32'd5, 32'd7, 8'd9, 32'h5678, 0, 0);
        send_request(MODE_APPEND, 32'd5, 32'd0, 8'd1, 32'h9abc, 0, 0);
        send_request(MODE_APPEND, 32'd5, 32'd11, 8'd2, 32'hdef0, 0, 0);
        send_request(MODE_LATEST, '1, '1, 8'hff, '1, '1, 6'h3f);
        // List: zero limit, large limit, bound in the middle, bound at the top.
        send_request(MODE_LIST, 0, 0, 0, 0, 0, 0);
        send_request(MODE_LIST, 0, 0, 0, 0, 0, 6'h3f);
        send_request(MODE_LIST, 0, 0, 0, 0, 32'd2, 6'd2);
        send_request(MODE_LIST, 0, 0, 0, 0, '1, 6'd32);
        // Receipts: zero limit still counts, limit of one, duplicates dropped, zero message.
        send_request(MODE_RECEIPTS, 32'd5, 0, 0, 0, 0, 0);
        send_request(MODE_RECEIPTS, 32'd5, 0, 0, 0, 0, 6'd1);
        send_request(MODE_RECEIPTS, 32'd5, 0, 0, 0, 0, 6'h3f);
        send_request(MODE_RECEIPTS, 32'd0, 0, 0, 0, 0, 6'h3f);
        send_request(MODE_RECEIPTS, '1, 0, 0, 0, 0, 6'd33);

        // Random traffic across four flow-control phases; enough appends to wrap
        // the ring several times.
        for (int k = 0; k < 460; k++)
        begin
            case ((k / 115) % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 51; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            send_random();
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("covered %0d appends, %0d latest, %0d list and %0d receipts requests",
                 n_append, n_latest, n_list, n_rcpt);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
